FILE: rtl/core/rwlt_pkg.sv
// ----------------------------------------------------------------------------
// rwlt_pkg
// Types and constants shared by the reader/writer lock table.
// ----------------------------------------------------------------------------
package rwlt_pkg;

  localparam int OP_W      = 3;
  localparam int SET_IDX_W = 20;
  localparam int WAY_IDX_W = 4;
  localparam int STATUS_W  = 3;
  localparam int LIVE_W    = 7;

  typedef enum logic [OP_W-1:0] {
    OP_ADD_READ  = 3'd0,
    OP_ADD_WRITE = 3'd1,
    OP_REM_READ  = 3'd2,
    OP_REM_WRITE = 3'd3,
    OP_QUERY     = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_READERS   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_NOT_HELD  = 3'd3,
    ST_COLLISION = 3'd4,
    ST_FULL      = 3'd5
  } status_e;

  typedef enum logic {
    FSM_IDLE,
    FSM_UPDATE
  } fsm_e;

  typedef struct packed {
    logic capture;
    logic update;
  } cmd_t;

endpackage

FILE: rtl/core/rwlt_if.sv
// ----------------------------------------------------------------------------
// rwlt_if
// Request and response channels of the lock table.
// ----------------------------------------------------------------------------
interface rwlt_req_if;
  import rwlt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      operation;
  logic [SET_IDX_W-1:0] set_index;
  logic [WAY_IDX_W-1:0] way_index;

  modport source (output valid, operation, set_index, way_index, input ready);
  modport sink   (input valid, operation, set_index, way_index, output ready);
endinterface

interface rwlt_rsp_if;
  import rwlt_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                lock_present;
  logic [LIVE_W-1:0]   live_entries;

  modport source (output valid, status, lock_present, live_entries, input ready);
  modport sink   (input valid, status, lock_present, live_entries, output ready);
endinterface

FILE: rtl/core/rwlt_ctrl.sv
// ----------------------------------------------------------------------------
// rwlt_ctrl
// Sequencer: takes a request, runs the update, owns the result valid flag.
// ----------------------------------------------------------------------------
module rwlt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          out_ready_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  output rwlt_pkg::cmd_t cmd_o
);
  import rwlt_pkg::*;

  fsm_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE: begin
        if (in_valid_i) state_d = FSM_UPDATE;
      end
      FSM_UPDATE: begin
        if (!out_valid_q || out_ready_i) state_d = FSM_IDLE;
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.update  = 1'b0;
    unique case (state_q)
      FSM_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      FSM_UPDATE: begin
        cmd_o.update = !out_valid_q || out_ready_i;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.update)     out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/core/rwlt_datapath.sv
// ----------------------------------------------------------------------------
// rwlt_datapath
// Lock entries, parallel key match, free-slot pick, update and result register.
// ----------------------------------------------------------------------------
module rwlt_datapath #(
  parameter int TABLE_SLOTS = 64,
  parameter int SET_BITS    = 20,
  parameter int WAY_BITS    = 4,
  parameter int READER_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rwlt_pkg::cmd_t                 cmd_i,
  input  logic [rwlt_pkg::OP_W-1:0]      operation_i,
  input  logic [rwlt_pkg::SET_IDX_W-1:0] set_index_i,
  input  logic [rwlt_pkg::WAY_IDX_W-1:0] way_index_i,
  output logic [rwlt_pkg::STATUS_W-1:0]  status_o,
  output logic                           lock_present_o,
  output logic [rwlt_pkg::LIVE_W-1:0]    live_entries_o
);
  import rwlt_pkg::*;

  localparam int CNT_W = $clog2(TABLE_SLOTS + 1);

  logic [TABLE_SLOTS-1:0] valid_q;
  logic [SET_BITS-1:0]    set_q  [TABLE_SLOTS];
  logic [WAY_BITS-1:0]    way_q  [TABLE_SLOTS];
  logic [READER_BITS-1:0] rd_q   [TABLE_SLOTS];
  logic [TABLE_SLOTS-1:0] wr_q;
  logic [CNT_W-1:0]       cnt_q, cnt_d;

  logic [SET_BITS+SET_IDX_W-1:0] set_ext;
  logic [WAY_BITS+WAY_IDX_W-1:0] way_ext;
  logic [SET_BITS-1:0]           set_key;
  logic [WAY_BITS-1:0]           way_key;
  logic [TABLE_SLOTS-1:0]        match;
  logic [TABLE_SLOTS-1:0]        free_vec;
  logic [TABLE_SLOTS-1:0]        spare_vec;

  logic [OP_W-1:0]        op_q;
  logic [SET_BITS-1:0]    set_key_q;
  logic [WAY_BITS-1:0]    way_key_q;
  logic [TABLE_SLOTS-1:0] hit_q;
  logic [TABLE_SLOTS-1:0] spare_q;

  logic [READER_BITS-1:0] rd_sel;
  logic                   wr_sel;
  logic                   hit_any;
  logic                   full;
  logic                   ins;
  logic [READER_BITS-1:0] ins_rd;
  logic                   ins_wr;
  logic                   hit_wr;
  logic [READER_BITS-1:0] rd_new;
  logic                   wr_new;
  logic                   free_hit;
  status_e                status;
  logic [CNT_W+LIVE_W-1:0] live_ext;

  logic [STATUS_W-1:0] status_q;
  logic                present_q;
  logic [LIVE_W-1:0]   live_q;

  // key fields narrowed or widened to the stored key width
  assign set_ext = {{SET_BITS{1'b0}}, set_index_i};
  assign way_ext = {{WAY_BITS{1'b0}}, way_index_i};
  assign set_key = set_ext[SET_BITS-1:0];
  assign way_key = way_ext[WAY_BITS-1:0];

  always_comb begin
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      match[i] = valid_q[i] && (set_q[i] == set_key) && (way_q[i] == way_key);
    end
  end

  // lowest free slot as a one-hot vector
  assign free_vec  = ~valid_q;
  assign spare_vec = free_vec & (~free_vec + 1'b1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q      <= operation_i;
      set_key_q <= set_key;
      way_key_q <= way_key;
      hit_q     <= match;
      spare_q   <= spare_vec;
    end
  end

  always_comb begin
    rd_sel = '0;
    wr_sel = 1'b0;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      rd_sel = rd_sel | (rd_q[i] & {READER_BITS{hit_q[i]}});
      wr_sel = wr_sel | (wr_q[i] & hit_q[i]);
    end
  end

  assign hit_any = |hit_q;
  assign full    = ~|spare_q;

  always_comb begin
    status   = ST_OK;
    ins      = 1'b0;
    ins_rd   = '0;
    ins_wr   = 1'b0;
    hit_wr   = 1'b0;
    rd_new   = rd_sel;
    wr_new   = wr_sel;
    free_hit = 1'b0;
    case (op_q)
      OP_ADD_READ: begin
        if (hit_any) begin
          hit_wr = 1'b1;
          if (rd_sel != '1) rd_new = rd_sel + 1'b1;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          ins    = 1'b1;
          ins_rd = READER_BITS'(1);
        end
      end
      OP_ADD_WRITE: begin
        if (hit_any) begin
          if (rd_sel != '0) status = ST_READERS;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          ins    = 1'b1;
          ins_wr = 1'b1;
        end
      end
      OP_REM_READ: begin
        if (!hit_any) begin
          status = ST_NOT_FOUND;
        end else if (rd_sel == '0) begin
          status = ST_NOT_HELD;
        end else begin
          hit_wr   = 1'b1;
          rd_new   = rd_sel - 1'b1;
          free_hit = (rd_new == '0) && !wr_sel;
        end
      end
      OP_REM_WRITE: begin
        if (!hit_any) begin
          status = ST_NOT_FOUND;
        end else if (!wr_sel) begin
          status = ST_NOT_HELD;
        end else begin
          hit_wr = 1'b1;
          wr_new = 1'b0;
          if (rd_sel == '0) free_hit = 1'b1;
          else              status   = ST_COLLISION;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (ins)           cnt_d = cnt_q + 1'b1;
    else if (free_hit) cnt_d = cnt_q - 1'b1;
  end

  assign live_ext = {{LIVE_W{1'b0}}, cnt_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      cnt_q   <= '0;
    end else if (cmd_i.update) begin
      cnt_q <= cnt_d;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        if (ins && spare_q[i])          valid_q[i] <= 1'b1;
        else if (free_hit && hit_q[i])  valid_q[i] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        if (ins && spare_q[i]) begin
          set_q[i] <= set_key_q;
          way_q[i] <= way_key_q;
          rd_q[i]  <= ins_rd;
          wr_q[i]  <= ins_wr;
        end else if (hit_wr && hit_q[i]) begin
          rd_q[i] <= rd_new;
          wr_q[i] <= wr_new;
        end
      end
      status_q  <= status;
      present_q <= hit_any;
      live_q    <= live_ext[LIVE_W-1:0];
    end
  end

  assign status_o       = status_q;
  assign lock_present_o = present_q;
  assign live_entries_o = live_q;

endmodule

FILE: rtl/core/reader_writer_lock_table_top.sv
// ----------------------------------------------------------------------------
// reader_writer_lock_table_top
// Reader/writer lock table keyed by cache set and way.
//
//   Channel  Dir  Item
//   req_i    in   operation, set_index, way_index
//   rsp_o    out  status, lock_present, live_entries
//
// The key match against every slot and the free-slot pick are registered
// when the request is taken; the entry update and the result load follow
// in the update state, once the result register is free to take them.
// Reset empties the table at once; no clearing pass.
// A held result stalls only the update step; a new request is taken as soon
// as the previous update has loaded the result register.
// ----------------------------------------------------------------------------
module reader_writer_lock_table_top #(
  parameter int TABLE_SLOTS = 64,
  parameter int SET_BITS    = 20,
  parameter int WAY_BITS    = 4,
  parameter int READER_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rwlt_req_if.sink   req_i,
  rwlt_rsp_if.source rsp_o
);
  import rwlt_pkg::*;

  cmd_t cmd;

  rwlt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .out_ready_i (rsp_o.ready),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .cmd_o       (cmd)
  );

  rwlt_datapath #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .SET_BITS    (SET_BITS),
    .WAY_BITS    (WAY_BITS),
    .READER_BITS (READER_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .operation_i    (req_i.operation),
    .set_index_i    (req_i.set_index),
    .way_index_i    (req_i.way_index),
    .status_o       (rsp_o.status),
    .lock_present_o (rsp_o.lock_present),
    .live_entries_o (rsp_o.live_entries)
  );

endmodule

FILE: bench/reader_writer_lock_table_top_tb.sv
// ----------------------------------------------------------------------------
// reader_writer_lock_table_top_tb
// Self-checking bench for the reader/writer lock table. A behavioural mirror
// of the table predicts status, hit flag and live count for every request
// item. Every response item is compared against the oldest prediction.
// Stimulus is a short directed opening, then randomised churn and table-fill
// episodes, each drained afterwards. Both channels idle at random, except in the steady fill episode.
// ----------------------------------------------------------------------------
module reader_writer_lock_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rwlt_pkg::*;

  localparam int SLOTS    = 64;
  localparam int READER_W = 16;
  localparam int OP_CODES = 1 << OP_W;
  localparam int LIMIT    = 1_500_000;

  class lock_table_mirror;
    typedef struct {
      status_e           status;
      logic              present;
      logic [LIVE_W-1:0] live;
    } verdict_t;

    bit                   used[SLOTS];
    logic [SET_IDX_W-1:0] key_set[SLOTS];
    logic [WAY_IDX_W-1:0] key_way[SLOTS];
    logic [READER_W-1:0]  readers[SLOTS];
    bit                   writer[SLOTS];
    int                   live;
    verdict_t             awaited[$];
    int                   failures;

    function int slot_of(logic [SET_IDX_W-1:0] s, logic [WAY_IDX_W-1:0] w);
      for (int i = 0; i < SLOTS; i++)
        if (used[i] && key_set[i] == s && key_way[i] == w) return i;
      return -1;
    endfunction

    function void free_entry(int i);
      used[i]    = 1'b0;
      readers[i] = '0;
      writer[i]  = 1'b0;
      live--;
    endfunction

    function void take_request(logic [OP_W-1:0] op, logic [SET_IDX_W-1:0] s,
                               logic [WAY_IDX_W-1:0] w);
      int       hit;
      int       spare;
      verdict_t v;
      hit   = slot_of(s, w);
      spare = -1;
      for (int i = SLOTS - 1; i >= 0; i--)
        if (!used[i]) spare = i;
      v.status  = ST_OK;
      v.present = (hit >= 0);
      case (op)
        OP_ADD_READ, OP_ADD_WRITE: begin
          if (hit >= 0) begin
            if (op == OP_ADD_READ) begin
              if (readers[hit] != '1) readers[hit]++;
            end else if (readers[hit] != 0) begin
              v.status = ST_READERS;
            end
          end else if (spare < 0) begin
            v.status = ST_FULL;
          end else begin
            used[spare]    = 1'b1;
            key_set[spare] = s;
            key_way[spare] = w;
            readers[spare] = (op == OP_ADD_READ) ? 1 : 0;
            writer[spare]  = (op == OP_ADD_WRITE);
            live++;
          end
        end
        OP_REM_READ: begin
          if (hit < 0) begin
            v.status = ST_NOT_FOUND;
          end else if (readers[hit] == 0) begin
            v.status = ST_NOT_HELD;
          end else begin
            readers[hit]--;
            if (readers[hit] == 0 && !writer[hit]) free_entry(hit);
          end
        end
        OP_REM_WRITE: begin
          if (hit < 0) begin
            v.status = ST_NOT_FOUND;
          end else if (!writer[hit]) begin
            v.status = ST_NOT_HELD;
          end else begin
            writer[hit] = 1'b0;
            if (readers[hit] == 0) free_entry(hit);
            else v.status = ST_COLLISION;
          end
        end
        default: ;
      endcase
      v.live = LIVE_W'(live);
      awaited.push_back(v);
    endfunction

    function void compare(string field, logic [31:0] expected, logic [31:0] actual);
      if (actual !== expected) begin
        failures++;
        if (failures <= 40)
          $error("%s: expected %0d, got %0d", field, expected, actual);
      end
    endfunction

    function void check_response(logic [STATUS_W-1:0] status, logic present,
                                 logic [LIVE_W-1:0] live_entries);
      verdict_t v;
      if (awaited.size() == 0) begin
        failures++;
        if (failures <= 40) $error("response item with none outstanding");
        return;
      end
      v = awaited.pop_front();
      compare("status", 32'(v.status), 32'(status));
      compare("lock_present", 32'(v.present), 32'(present));
      compare("live_entries", 32'(v.live), 32'(live_entries));
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  bit   steady = 1'b0;
  int   accepted;
  int   cycles;
  lock_table_mirror mirror;

  rwlt_req_if req ();
  rwlt_rsp_if rsp ();

  reader_writer_lock_table_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    rsp.ready = steady || ($urandom_range(99) >= 6);
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp.valid === 1'b1 && rsp.ready)
      mirror.check_response(rsp.status, rsp.lock_present, rsp.live_entries);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send(input logic [OP_W-1:0] op, input logic [SET_IDX_W-1:0] s,
                      input logic [WAY_IDX_W-1:0] w);
    @(negedge clk_i);
    while (!steady && $urandom_range(99) < 6) begin
      req.valid = 1'b0;
      @(negedge clk_i);
    end
    req.valid     = 1'b1;
    req.operation = op;
    req.set_index = s;
    req.way_index = w;
    do @(posedge clk_i); while (req.ready !== 1'b1);
    mirror.take_request(op, s, w);
    accepted++;
  endtask

  // drops every hold on a key until its entry is gone
  task automatic release_key(input logic [SET_IDX_W-1:0] s, input logic [WAY_IDX_W-1:0] w);
    int idx;
    idx = mirror.slot_of(s, w);
    while (idx >= 0) begin
      if (mirror.writer[idx]) send(OP_REM_WRITE, s, w);
      else send(OP_REM_READ, s, w);
      idx = mirror.slot_of(s, w);
    end
  endtask

  function automatic logic [SET_IDX_W-1:0] pick_set();
    int r;
    r = $urandom_range(3);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return SET_IDX_W'($urandom);
  endfunction

  initial begin
    logic [SET_IDX_W-1:0] pool_set[$];
    logic [WAY_IDX_W-1:0] pool_way[$];
    logic [SET_IDX_W-1:0] sets[$];
    logic [WAY_IDX_W-1:0] ways[$];
    logic [SET_IDX_W-1:0] s;
    logic [OP_W-1:0]      op;
    int                   n;
    int                   pick;
    int                   r;
    int                   episode;
    int                   goal;

    mirror        = new();
    req.valid     = 1'b0;
    req.operation = OP_QUERY;
    req.set_index = '0;
    req.way_index = '0;
    rsp.ready     = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty table, then reader stacking on the lowest key
    send(OP_QUERY, '0, '0);
    send(OP_REM_READ, '0, '0);
    send(OP_REM_WRITE, '0, '0);
    send(OP_ADD_READ, '0, '0);
    send(OP_ADD_READ, '0, '0);
    send(OP_ADD_WRITE, '0, '0);
    send(OP_REM_WRITE, '0, '0);
    send(OP_REM_READ, '0, '0);
    send(OP_REM_READ, '0, '0);
    send(OP_REM_READ, '0, '0);
    // writer on the highest key, reader added on top, collision on release
    send(OP_ADD_WRITE, '1, '1);
    send(OP_ADD_WRITE, '1, '1);
    send(OP_ADD_READ, '1, '1);
    send(OP_QUERY, '1, '0);
    send(OP_REM_WRITE, '1, '1);
    send(OP_REM_WRITE, '1, '1);
    for (int c = int'(OP_QUERY) + 1; c < OP_CODES; c++) send(OP_W'(c), '1, '1);
    send(OP_REM_READ, '1, '1);
    // writer only: a reader release is not held
    send(OP_ADD_WRITE, '1, '0);
    send(OP_REM_READ, '1, '0);
    send(OP_REM_WRITE, '1, '0);

    goal    = accepted + 850;
    episode = 0;
    while (accepted < goal) begin
      steady = (episode == 2);
      pool_set.delete();
      pool_way.delete();
      if (episode == 1 || episode == 2 || $urandom_range(5) == 0) begin
        // fill past capacity, free one slot, refill, then drain
        s = pick_set();
        n = SLOTS + $urandom_range(1, 6);
        for (int k = 0; k < n; k++) begin
          pool_set.push_back(s + SET_IDX_W'(k));
          pool_way.push_back(WAY_IDX_W'($urandom));
        end
        for (int k = 0; k < n; k++)
          send($urandom_range(1) ? OP_ADD_READ : OP_ADD_WRITE, pool_set[k], pool_way[k]);
        repeat (4) begin
          pick = $urandom_range(n - 1);
          send(OP_QUERY, pool_set[pick], pool_way[pick]);
        end
        pick = $urandom_range(SLOTS - 1);
        release_key(pool_set[pick], pool_way[pick]);
        send(OP_ADD_WRITE, pool_set[n-1], pool_way[n-1]);
        send(OP_ADD_READ, pool_set[n-1], pool_way[n-1]);
      end else begin
        // small key pool sharing sets and ways, random operations
        sets.delete();
        ways.delete();
        repeat ($urandom_range(1, 3)) sets.push_back(pick_set());
        repeat ($urandom_range(1, 4)) ways.push_back(WAY_IDX_W'($urandom));
        foreach (sets[a])
          foreach (ways[b]) begin
            pool_set.push_back(sets[a]);
            pool_way.push_back(ways[b]);
          end
        pool_set.push_back(SET_IDX_W'($urandom));
        pool_way.push_back(WAY_IDX_W'($urandom));
        repeat ($urandom_range(30, 80)) begin
          pick = $urandom_range(pool_set.size() - 1);
          r    = $urandom_range(99);
          if (r < 30) op = OP_ADD_READ;
          else if (r < 48) op = OP_ADD_WRITE;
          else if (r < 68) op = OP_REM_READ;
          else if (r < 86) op = OP_REM_WRITE;
          else if (r < 95) op = OP_QUERY;
          else op = OP_W'($urandom_range(int'(OP_QUERY) + 1, OP_CODES - 1));
          send(op, pool_set[pick], pool_way[pick]);
        end
      end
      foreach (pool_set[k]) release_key(pool_set[k], pool_way[k]);
      episode++;
    end
    steady = 1'b0;

    @(negedge clk_i);
    req.valid = 1'b0;
    while (mirror.awaited.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mirror.failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/rwlt_pkg.sv
rtl/core/rwlt_if.sv
rtl/core/rwlt_ctrl.sv
rtl/core/rwlt_datapath.sv
rtl/core/reader_writer_lock_table_top.sv
bench/reader_writer_lock_table_top_tb.sv
